// ===== sv/vpc_pkg.sv =====
// Shared widths, beat types, queue entry and back-end state codes.
package vpc_pkg;

  localparam int VIS_W   = 24;
  localparam int FEED_W  = 8;
  localparam int TOL_W   = 51;
  localparam int EXP_W   = 2 * FEED_W + 1;
  localparam int DIFF_W  = VIS_W + 1;
  localparam int SQ_W    = 2 * VIS_W - 1;
  localparam int R2_W    = SQ_W + 1;
  localparam int ROOT_W  = R2_W / 2;
  localparam int ERR_W   = 25;
  localparam int TALLY_W = 17;
  localparam int SUM_W   = 41;

  localparam int ROOT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = SUM_W;
  localparam int CNT_W      = 6;

  localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(1);
  localparam logic [TALLY_W-1:0] TALLY_CAP = TALLY_W'(65536);
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [ERR_W-1:0]   ERR_MAX   = {ERR_W{1'b1}};

  typedef struct packed {
    logic signed [VIS_W-1:0]  vis_re;
    logic signed [VIS_W-1:0]  vis_im;
    logic signed [FEED_W-1:0] feed_a_re;
    logic signed [FEED_W-1:0] feed_a_im;
    logic signed [FEED_W-1:0] feed_b_re;
    logic signed [FEED_W-1:0] feed_b_im;
    logic                     frame_end;
  } vis_beat_t;

  typedef struct packed {
    logic [TALLY_W-1:0] bad_count;
    logic [ERR_W-1:0]   mean_error;
    logic [ERR_W-1:0]   least_error;
    logic [ERR_W-1:0]   greatest_error;
  } sum_beat_t;

  // Classified element handed from front to back
  typedef struct packed {
    logic [R2_W-1:0] r2;
    logic            bad;
    logic            last;
  } q_entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROOT,
    B_UPDATE,
    B_FRAME,
    B_DIV,
    B_EMIT
  } back_state_t;

endpackage

// ===== sv/vpc_if.sv =====
// Valid/ready channel interfaces for visibility and summary beats.
interface vpc_vis_if;
  logic                valid;
  logic                ready;
  vpc_pkg::vis_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vpc_sum_if;
  logic                valid;
  logic                ready;
  vpc_pkg::sum_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/vpc_front.sv =====
// Front end: expected product, squared error and tolerance compare, one beat a cycle unless a push meets a full queue.
module vpc_front (
  input  logic                        clk,
  input  logic                        rst,
  vpc_vis_if.sink                     vis,
  input  logic [vpc_pkg::TOL_W-1:0]   tolerance,
  input  logic                        q_full,
  output logic                        q_push,
  output vpc_pkg::q_entry_t           q_data
);

  localparam int VW = vpc_pkg::VIS_W;
  localparam int FW = vpc_pkg::FEED_W;
  localparam int EW = vpc_pkg::EXP_W;
  localparam int DW = vpc_pkg::DIFF_W;
  localparam int SW = vpc_pkg::SQ_W;
  localparam int RW = vpc_pkg::R2_W;
  localparam int TW = vpc_pkg::TOL_W;

  logic                 advance;
  logic                 s2_need;

  // stage 1 registers
  logic                 s1_valid;
  logic signed [VW-1:0] s1_vis_re;
  logic signed [VW-1:0] s1_vis_im;
  logic signed [EW-1:0] s1_exp_re;
  logic signed [EW-1:0] s1_exp_im;
  logic                 s1_last;

  // stage 2 registers
  logic                 s2_valid;
  logic [SW-1:0]        s2_sq_re;
  logic [SW-1:0]        s2_sq_im;
  logic                 s2_last;

  logic signed [2*FW-1:0] p_rr, p_ii, p_ir, p_ri;
  logic signed [EW-1:0]   exp_re, exp_im;
  logic signed [DW-1:0]   d_re, d_im;
  logic signed [2*DW-1:0] sq_re_full, sq_im_full;
  logic [RW-1:0]          r2;
  logic                   bad;

  // expected = a * conj(b)
  always_comb begin
    p_rr   = vis.data.feed_a_re * vis.data.feed_b_re;
    p_ii   = vis.data.feed_a_im * vis.data.feed_b_im;
    p_ir   = vis.data.feed_a_im * vis.data.feed_b_re;
    p_ri   = vis.data.feed_a_re * vis.data.feed_b_im;
    exp_re = {p_rr[2*FW-1], p_rr} + {p_ii[2*FW-1], p_ii};
    exp_im = {p_ir[2*FW-1], p_ir} - {p_ri[2*FW-1], p_ri};
  end

  // difference and square
  always_comb begin
    d_re = {s1_vis_re[VW-1], s1_vis_re} - {{(DW-EW){s1_exp_re[EW-1]}}, s1_exp_re};
    d_im = {s1_vis_im[VW-1], s1_vis_im} - {{(DW-EW){s1_exp_im[EW-1]}}, s1_exp_im};
    sq_re_full = d_re * d_re;
    sq_im_full = d_im * d_im;
  end

  // sum of squares and classify
  always_comb begin
    r2      = {1'b0, s2_sq_re} + {1'b0, s2_sq_im};
    bad     = {{(TW-RW){1'b0}}, r2} > tolerance;
    s2_need = bad | s2_last;
    advance = !(s2_valid && s2_need && q_full);
    q_push  = s2_valid && s2_need && !q_full;
    q_data.r2   = r2;
    q_data.bad  = bad;
    q_data.last = s2_last;
  end

  assign vis.ready = advance;

  // advance the pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= vis.valid;
      s2_valid <= s1_valid;
    end
  end

  // advance the payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_vis_re <= vis.data.vis_re;
      s1_vis_im <= vis.data.vis_im;
      s1_exp_re <= exp_re;
      s1_exp_im <= exp_im;
      s1_last   <= vis.data.frame_end;
      s2_sq_re  <= sq_re_full[SW-1:0];
      s2_sq_im  <= sq_im_full[SW-1:0];
      s2_last   <= s1_last;
    end
  end

endmodule

// ===== sv/vpc_queue.sv =====
// Short FIFO of classified elements between front and back.
module vpc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vpc_pkg::q_entry_t  push_data,
  output logic               full,
  input  logic               pop,
  output vpc_pkg::q_entry_t  pop_data,
  output logic               empty
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  vpc_pkg::q_entry_t slots [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       fill;

  assign full     = fill == (AW+1)'(DEPTH);
  assign empty    = fill == '0;
  assign pop_data = slots[rd_ptr];

  // move pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      if (push && !pop)      fill <= fill + (AW+1)'(1);
      else if (pop && !push) fill <= fill - (AW+1)'(1);
    end
  end

  // store the beat
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== sv/vpc_back.sv =====
// Back end: bit-serial square root, frame accumulators, serial mean divide, summary register.
module vpc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  vpc_pkg::q_entry_t  q_data,
  output logic               q_pop,
  vpc_sum_if.source          summary
);

  localparam int RW  = vpc_pkg::R2_W;
  localparam int QW  = vpc_pkg::ROOT_W;
  localparam int EW  = vpc_pkg::ERR_W;
  localparam int TW  = vpc_pkg::TALLY_W;
  localparam int SW  = vpc_pkg::SUM_W;
  localparam int CW  = vpc_pkg::CNT_W;
  localparam int RMW = QW + 3;

  vpc_pkg::back_state_t state, state_next;

  logic              last;
  logic [RW-1:0]     root_n;
  logic [RMW-1:0]    root_rem;
  logic [QW-1:0]     root_q;
  logic [CW-1:0]     cnt;
  logic [TW-1:0]     tally;
  logic [SW-1:0]     err_sum;
  logic [EW-1:0]     low_err;
  logic [EW-1:0]     high_err;
  logic [TW-1:0]     div_rem;
  logic [SW-1:0]     div_q;

  logic              out_load;
  logic              cnt_done_root;
  logic              cnt_done_div;

  logic [RMW-1:0]    rt_sh, rt_trial, rt_rem_new;
  logic              rt_ge;
  logic [TW:0]       dv_sh;
  logic              dv_ge;
  logic [TW-1:0]     dv_rem_new;
  logic [EW-1:0]     err;
  logic [SW:0]       sum_add;
  logic [EW-1:0]     mean;

  // one root digit per cycle
  always_comb begin
    rt_sh      = {root_rem[RMW-3:0], root_n[RW-1 -: 2]};
    rt_trial   = {1'b0, root_q, 2'b01};
    rt_ge      = rt_sh >= rt_trial;
    rt_rem_new = rt_ge ? rt_sh - rt_trial : rt_sh;
  end

  // one quotient bit per cycle
  always_comb begin
    dv_sh      = {div_rem, div_q[SW-1]};
    dv_ge      = dv_sh >= {1'b0, tally};
    dv_rem_new = dv_ge ? TW'(dv_sh - {1'b0, tally}) : dv_sh[TW-1:0];
  end

  // accumulate and clamp
  always_comb begin
    err     = {{(EW-QW){1'b0}}, root_q};
    sum_add = {1'b0, err_sum} + (SW+1)'(err);
    mean    = (div_q > SW'(vpc_pkg::ERR_MAX)) ? vpc_pkg::ERR_MAX : div_q[EW-1:0];
  end

  assign cnt_done_root = cnt == CW'(vpc_pkg::ROOT_STEPS - 1);
  assign cnt_done_div  = cnt == CW'(vpc_pkg::DIV_STEPS - 1);

  // next state and strobes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      vpc_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = q_data.bad ? vpc_pkg::B_ROOT : vpc_pkg::B_FRAME;
        end
      end
      vpc_pkg::B_ROOT: begin
        if (cnt_done_root) state_next = vpc_pkg::B_UPDATE;
      end
      vpc_pkg::B_UPDATE: begin
        state_next = last ? vpc_pkg::B_FRAME : vpc_pkg::B_IDLE;
      end
      vpc_pkg::B_FRAME: begin
        state_next = (tally == '0) ? vpc_pkg::B_EMIT : vpc_pkg::B_DIV;
      end
      vpc_pkg::B_DIV: begin
        if (cnt_done_div) state_next = vpc_pkg::B_EMIT;
      end
      vpc_pkg::B_EMIT: begin
        if (!summary.valid || summary.ready) begin
          out_load   = 1'b1;
          state_next = vpc_pkg::B_IDLE;
        end
      end
      default: state_next = vpc_pkg::B_IDLE;
    endcase
  end

  // hold the state
  always_ff @(posedge clk) begin
    if (rst) state <= vpc_pkg::B_IDLE;
    else     state <= state_next;
  end

  // frame accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      tally    <= '0;
      err_sum  <= '0;
      low_err  <= '0;
      high_err <= '0;
    end else if (state == vpc_pkg::B_UPDATE) begin
      if (tally == '0) begin
        low_err  <= err;
        high_err <= err;
      end else begin
        if (err < low_err)  low_err  <= err;
        if (err > high_err) high_err <= err;
      end
      if (tally < vpc_pkg::TALLY_CAP) begin
        tally   <= tally + TW'(1);
        err_sum <= (sum_add > {1'b0, vpc_pkg::SUM_MAX}) ? vpc_pkg::SUM_MAX : sum_add[SW-1:0];
      end
    end else if (out_load) begin
      tally    <= '0;
      err_sum  <= '0;
      low_err  <= '0;
      high_err <= '0;
    end
  end

  // root and divide datapath
  always_ff @(posedge clk) begin
    case (state)
      vpc_pkg::B_IDLE: begin
        last     <= q_data.last;
        root_n   <= q_data.r2;
        root_rem <= '0;
        root_q   <= '0;
        cnt      <= '0;
      end
      vpc_pkg::B_ROOT: begin
        root_rem <= rt_rem_new;
        root_q   <= {root_q[QW-2:0], rt_ge};
        root_n   <= {root_n[RW-3:0], 2'b00};
        cnt      <= cnt + CW'(1);
      end
      vpc_pkg::B_FRAME: begin
        div_rem <= '0;
        div_q   <= err_sum;
        cnt     <= '0;
      end
      vpc_pkg::B_DIV: begin
        div_rem <= dv_rem_new;
        div_q   <= {div_q[SW-2:0], dv_ge};
        cnt     <= cnt + CW'(1);
      end
      default: begin
      end
    endcase
  end

  // summary output register
  always_ff @(posedge clk) begin
    if (rst) summary.valid <= 1'b0;
    else if (out_load) summary.valid <= 1'b1;
    else if (summary.ready) summary.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      summary.data.bad_count      <= tally;
      summary.data.mean_error     <= (tally == '0) ? '0 : mean;
      summary.data.least_error    <= (tally == '0) ? '0 : low_err;
      summary.data.greatest_error <= (tally == '0) ? '0 : high_err;
    end
  end

endmodule

// ===== sv/visibility_pattern_checker_unit.sv =====
// Top level of the visibility test-pattern checker.
//
// Channels: vis takes one visibility beat (measured value, both feed
// pattern values, frame_end); summary gives one beat per frame with the
// bad count, floor mean, least and greatest error. cfg_write with cfg_data
// loads the squared tolerance; it resets to 1.
// Throughput: the front end takes one beat every cycle unless a push meets a full queue. An
// element within tolerance costs nothing further. A bad element holds the back end for the
// dequeue, the 24-bit root and one update; a four-entry queue absorbs short bursts, after
// which vis.ready drops until the root unit frees. An element passes the stage 1 and stage 2
// registers to reach the queue; a frame end then goes through B_FRAME, the serial divider
// (skipped for an empty tally) and B_EMIT, which loads the summary register.
// Reset clears the pipeline, the queue, the accumulators and summary.valid.
// If summary is stalled the finished beat holds; the back end waits with
// the next summary until it is taken, and the front end runs on until the
// queue fills.
module visibility_pattern_checker_unit (
  input  logic                        clk,
  input  logic                        rst,
  vpc_vis_if.sink                     vis,
  vpc_sum_if.source                   summary,
  input  logic                        cfg_write,
  input  logic [vpc_pkg::TOL_W-1:0]   cfg_data
);

  logic [vpc_pkg::TOL_W-1:0] tolerance;
  logic                      q_push;
  logic                      q_pop;
  logic                      q_full;
  logic                      q_empty;
  vpc_pkg::q_entry_t         q_in;
  vpc_pkg::q_entry_t         q_out;

  // hold the tolerance register
  always_ff @(posedge clk) begin
    if (rst)            tolerance <= vpc_pkg::TOL_RESET;
    else if (cfg_write) tolerance <= cfg_data;
  end

  vpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .vis       (vis),
    .tolerance (tolerance),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  vpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  vpc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .summary (summary)
  );

endmodule

// ===== sv/vpc_checker.sv =====
// Port-level checks on the summary channel, bound to the top level.
module vpc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          sum_valid,
  input logic                          sum_ready,
  input logic [vpc_pkg::TALLY_W-1:0]   bad_count,
  input logic [vpc_pkg::ERR_W-1:0]     mean_error,
  input logic [vpc_pkg::ERR_W-1:0]     least_error,
  input logic [vpc_pkg::ERR_W-1:0]     greatest_error
);

  // summary is empty straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !sum_valid)
    else $error("summary valid after reset");

  // a stalled summary beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    sum_valid && !sum_ready |=> sum_valid && $stable({bad_count, mean_error,
                                                      least_error, greatest_error}))
    else $error("stalled summary beat changed");

  // an empty frame reports all zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    sum_valid && bad_count == '0 |-> mean_error == '0 && least_error == '0
                                     && greatest_error == '0)
    else $error("empty frame with nonzero errors");

  // mean lies between least and greatest
  a_order: assert property (@(posedge clk) disable iff (rst)
    sum_valid && bad_count != '0 |-> least_error <= mean_error
                                     && mean_error <= greatest_error)
    else $error("mean outside least and greatest");

  // the tally never passes its cap
  a_cap: assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> bad_count <= vpc_pkg::TALLY_CAP)
    else $error("bad count above cap");

endmodule

bind visibility_pattern_checker_unit vpc_checker u_vpc_checker (
  .clk            (clk),
  .rst            (rst),
  .sum_valid      (summary.valid),
  .sum_ready      (summary.ready),
  .bad_count      (summary.data.bad_count),
  .mean_error     (summary.data.mean_error),
  .least_error    (summary.data.least_error),
  .greatest_error (summary.data.greatest_error)
);

// ===== verif/vpc_summary_checker.sv =====
// Watches the visibility and summary channels, predicts each frame summary and compares it.
module vpc_summary_checker (
  input  logic                      clk,
  input  logic                      rst,
  vpc_vis_if                        vis,
  vpc_sum_if                        summary,
  input  logic                      cfg_write,
  input  logic [vpc_pkg::TOL_W-1:0] cfg_data,
  output int                        failures,
  output int                        outstanding
);

  localparam int TOL_W   = vpc_pkg::TOL_W;
  localparam int TALLY_W = vpc_pkg::TALLY_W;
  localparam int SUM_W   = vpc_pkg::SUM_W;
  localparam int ERR_W   = vpc_pkg::ERR_W;

  // Own copy of the register and the per-frame accumulators
  logic [TOL_W-1:0]   tol_sq;
  logic [TALLY_W-1:0] frame_bad;
  logic [SUM_W-1:0]   frame_sum;
  logic [ERR_W-1:0]   frame_low;
  logic [ERR_W-1:0]   frame_high;

  vpc_pkg::sum_beat_t expected_summaries[$];
  int                 fail_tally = 0;

  // Floor square root, one result bit per trial from the top down
  function automatic logic [31:0] floor_sqrt(input logic [63:0] n);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (64'(trial) * 64'(trial) <= n) root = trial;
    end
    return root;
  endfunction

  // Squared distance between the measured value and a * conj(b)
  function automatic logic [63:0] error_power(input vpc_pkg::vis_beat_t b);
    longint ar, ai, br, bi, dr, di;
    ar = longint'($signed(b.feed_a_re));
    ai = longint'($signed(b.feed_a_im));
    br = longint'($signed(b.feed_b_re));
    bi = longint'($signed(b.feed_b_im));
    dr = longint'($signed(b.vis_re)) - (ar * br + ai * bi);
    di = longint'($signed(b.vis_im)) - (ai * br - ar * bi);
    return 64'(dr * dr + di * di);
  endfunction

  task automatic clear_frame();
    frame_bad  = '0;
    frame_sum  = '0;
    frame_low  = '0;
    frame_high = '0;
  endtask

  // Fold one element into the frame; queue the summary at the frame end
  task automatic fold_element(input vpc_pkg::vis_beat_t b);
    logic [63:0]        r2;
    logic [63:0]        root;
    logic [ERR_W-1:0]   err;
    logic [SUM_W:0]     grown;
    logic [SUM_W-1:0]   mean_full;
    vpc_pkg::sum_beat_t s;
    r2 = error_power(b);
    if (r2 > 64'(tol_sq)) begin
      root = 64'(floor_sqrt(r2));
      err  = (root > 64'(vpc_pkg::ERR_MAX)) ? vpc_pkg::ERR_MAX : root[ERR_W-1:0];
      if (frame_bad == '0) begin
        frame_low  = err;
        frame_high = err;
      end else begin
        if (err < frame_low) frame_low = err;
        if (err > frame_high) frame_high = err;
      end
      // A full tally still moves the extremes but not the count or the sum
      if (frame_bad < vpc_pkg::TALLY_CAP) begin
        frame_bad = frame_bad + 1'b1;
        grown     = {1'b0, frame_sum} + (SUM_W + 1)'(err);
        frame_sum = grown[SUM_W] ? vpc_pkg::SUM_MAX : grown[SUM_W-1:0];
      end
    end
    if (b.frame_end) begin
      s = '0;
      if (frame_bad != '0) begin
        mean_full        = frame_sum / SUM_W'(frame_bad);
        s.bad_count      = frame_bad;
        s.mean_error     = (mean_full > SUM_W'(vpc_pkg::ERR_MAX)) ? vpc_pkg::ERR_MAX
                                                                  : mean_full[ERR_W-1:0];
        s.least_error    = frame_low;
        s.greatest_error = frame_high;
      end
      expected_summaries.push_back(s);
      clear_frame();
    end
  endtask

  // Sample both channels at each edge; take summaries before new elements
  always @(posedge clk) begin
    vpc_pkg::sum_beat_t want;
    if (rst) begin
      tol_sq = vpc_pkg::TOL_RESET;
      clear_frame();
      expected_summaries.delete();
    end else begin
      if (summary.valid && summary.ready) begin
        if (expected_summaries.size() == 0) begin
          $error("summary beat with no frame end waiting");
          fail_tally++;
        end else begin
          want = expected_summaries.pop_front();
          if (summary.data.bad_count !== want.bad_count) begin
            $error("bad_count: expected %0d, got %0d", want.bad_count, summary.data.bad_count);
            fail_tally++;
          end
          if (summary.data.mean_error !== want.mean_error) begin
            $error("mean_error: expected %0d, got %0d", want.mean_error,
                   summary.data.mean_error);
            fail_tally++;
          end
          if (summary.data.least_error !== want.least_error) begin
            $error("least_error: expected %0d, got %0d", want.least_error,
                   summary.data.least_error);
            fail_tally++;
          end
          if (summary.data.greatest_error !== want.greatest_error) begin
            $error("greatest_error: expected %0d, got %0d", want.greatest_error,
                   summary.data.greatest_error);
            fail_tally++;
          end
        end
      end
      if (vis.valid && vis.ready) fold_element(vis.data);
      if (cfg_write) tol_sq = cfg_data;
    end
    failures    <= fail_tally;
    outstanding <= expected_summaries.size();
  end

endmodule

// ===== verif/tb_visibility_pattern_checker_unit.sv =====
// Testbench top: clock, reset, visibility stimulus, summary back-pressure and verdict.
module tb_visibility_pattern_checker_unit;

  localparam int VIS_W  = vpc_pkg::VIS_W;
  localparam int FEED_W = vpc_pkg::FEED_W;
  localparam int TOL_W  = vpc_pkg::TOL_W;

  localparam int SETTLE_CYCLES = 200;    // queue, root unit and divider drain
  localparam int IDLE_LIMIT    = 20000;  // cycles with no beat moved
  localparam int LONG_HOLD     = 3000;
  localparam int PHASE_ITEMS   = 210;
  localparam logic [TOL_W-1:0] TOL_TOP = TOL_W'(64'd1 << 50);

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_write;
  logic [TOL_W-1:0] cfg_data;
  int               failures;
  int               outstanding;
  logic [TOL_W-1:0] cur_tol;
  int               hold_req = 0;
  int               holds_served = 0;
  int               idle_cycles = 0;

  vpc_vis_if vis_ch ();
  vpc_sum_if sum_ch ();

  visibility_pattern_checker_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .vis      (vis_ch),
    .summary  (sum_ch),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  vpc_summary_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .vis        (vis_ch),
    .summary    (sum_ch),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .failures   (failures),
    .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop the run if no beat moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (vis_ch.valid && vis_ch.ready) || (sum_ch.valid && sum_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("visibility_pattern_checker_unit: mismatch");
        $finish;
      end
    end
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_span();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(15, 70);
  endfunction

  function automatic logic [VIS_W-1:0] fit_vis(input longint v);
    if (v > 64'sd8388607) return VIS_W'(8388607);
    if (v < -64'sd8388608) return VIS_W'(-8388608);
    return VIS_W'(v);
  endfunction

  function automatic vpc_pkg::vis_beat_t mk_beat(input int vr, input int vi,
                                                 input int ar, input int ai,
                                                 input int br, input int bi, input bit fe);
    vpc_pkg::vis_beat_t b;
    b.vis_re    = VIS_W'(vr);
    b.vis_im    = VIS_W'(vi);
    b.feed_a_re = FEED_W'(ar);
    b.feed_a_im = FEED_W'(ai);
    b.feed_b_re = FEED_W'(br);
    b.feed_b_im = FEED_W'(bi);
    b.frame_end = fe;
    return b;
  endfunction

  // Random element: mostly near the pattern product, offset around the tolerance
  function automatic vpc_pkg::vis_beat_t random_beat(input bit fe);
    vpc_pkg::vis_beat_t b;
    longint             ar, ai, br, bi, er, ei, dr, di;
    int                 top_k;
    int                 k;
    logic [TOL_W-1:0]   t;
    b.feed_a_re = FEED_W'($urandom);
    b.feed_a_im = FEED_W'($urandom);
    b.feed_b_re = FEED_W'($urandom);
    b.feed_b_im = FEED_W'($urandom);
    if ($urandom_range(0, 15) == 0) begin
      b.feed_a_re = $urandom_range(0, 1) ? FEED_W'(-128) : FEED_W'(127);
      b.feed_a_im = $urandom_range(0, 1) ? FEED_W'(-128) : FEED_W'(127);
      b.feed_b_re = $urandom_range(0, 1) ? FEED_W'(-128) : FEED_W'(127);
      b.feed_b_im = $urandom_range(0, 1) ? FEED_W'(-128) : FEED_W'(127);
    end
    b.frame_end = fe;
    if ($urandom_range(0, 7) == 0) begin
      b.vis_re = VIS_W'($urandom);
      b.vis_im = VIS_W'($urandom);
    end else begin
      ar = longint'($signed(b.feed_a_re));
      ai = longint'($signed(b.feed_a_im));
      br = longint'($signed(b.feed_b_re));
      bi = longint'($signed(b.feed_b_im));
      er = ar * br + ai * bi;
      ei = ai * br - ar * bi;
      // Bits of the square root of the tolerance, plus headroom
      t = cur_tol;
      top_k = 2;
      while (t != '0) begin
        t = t >> 2;
        top_k++;
      end
      if (top_k > 23) top_k = 23;
      k  = $urandom_range(0, top_k);
      dr = longint'($urandom_range(0, 1 << k));
      if ($urandom_range(0, 1)) dr = -dr;
      k  = $urandom_range(0, top_k);
      di = longint'($urandom_range(0, 1 << k));
      if ($urandom_range(0, 1)) di = -di;
      b.vis_re = fit_vis(er + dr);
      b.vis_im = fit_vis(ei + di);
    end
    return b;
  endfunction

  // Offer one beat after an optional gap and hold it until taken
  task automatic send_beat(input vpc_pkg::vis_beat_t b, input int gap);
    if (gap > 0) begin
      vis_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vis_ch.valid <= 1'b1;
    vis_ch.data  <= b;
    do @(posedge clk); while (!vis_ch.ready);
  endtask

  // Drop valid and wait for every predicted summary
  task automatic drain();
    vis_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [TOL_W-1:0] v);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    cur_tol    = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Frames of random length; the phase always ends on a frame end
  task automatic run_frames(input int n, input bit burst, input bit pause_mid);
    int sent;
    int len;
    int gap;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      for (int j = 0; j < len && sent < n; j++) begin
        gap = (burst || $urandom_range(0, 99) < 65) ? 0 : idle_span();
        send_beat(random_beat((j == len - 1) || (sent == n - 1)), gap);
        sent++;
      end
      if (pause_mid && !paused && sent >= n / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  // Summary receiver: random stalls, ready stretches and one long hold-off
  initial begin
    forever begin
      if (hold_req != holds_served) begin
        holds_served = hold_req;
        sum_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        sum_ch.ready <= 1'b0;
        repeat (idle_span()) @(posedge clk);
      end else begin
        sum_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [TOL_W-1:0] tol_plan [8];
    tol_plan[0] = TOL_W'(1);
    tol_plan[1] = TOL_TOP;
    tol_plan[2] = '0;
    tol_plan[3] = TOL_W'(50);
    tol_plan[4] = TOL_W'(64'd1 << 20);
    tol_plan[5] = TOL_W'(64'd1 << 36);
    tol_plan[6] = TOL_W'({$urandom, $urandom}) >> $urandom_range(0, 50);
    tol_plan[7] = TOL_W'({$urandom, $urandom}) >> $urandom_range(20, 50);

    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_data     <= '0;
    vis_ch.valid <= 1'b0;
    vis_ch.data  <= '0;
    cur_tol       = vpc_pkg::TOL_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: tolerance boundary, empty frames, field extremes, min/max and floors
    send_beat(mk_beat(0, 0, 0, 0, 0, 0, 0), 0);
    send_beat(mk_beat(1, 0, 0, 0, 0, 0, 0), 0);
    send_beat(mk_beat(1, 1, 0, 0, 0, 0, 1), 0);
    send_beat(mk_beat(1, -31, 3, -2, 5, 7, 1), 0);
    send_beat(mk_beat(-8388608, -8388608, -128, -128, -128, -128, 0), 0);
    send_beat(mk_beat(8388607, 8388607, 127, 127, 127, 127, 0), 0);
    send_beat(mk_beat(8388607, -8388608, -128, 127, 127, -128, 0), 0);
    send_beat(mk_beat(0, 0, -128, -128, -128, 127, 1), 0);
    send_beat(mk_beat(5, 0, 0, 0, 0, 0, 0), 0);
    send_beat(mk_beat(3, 0, 0, 0, 0, 0, 0), 0);
    send_beat(mk_beat(9, 0, 0, 0, 0, 0, 0), 0);
    send_beat(mk_beat(3, 3, 0, 0, 0, 0, 1), 0);
    send_beat(mk_beat(0, 0, 0, 0, 0, 0, 1), 0);
    send_beat(mk_beat(-7, 2, 0, 0, 0, 0, 1), 0);
    send_beat(mk_beat(0, 1, 0, 0, 0, 0, 1), 0);

    // Random phases over a spread of tolerances
    for (int p = 0; p < 8; p++) begin
      set_tolerance(tol_plan[p]);
      if (p == 3) hold_req <= hold_req + 1;
      run_frames(PHASE_ITEMS, (p == 3) || (p == 6), p == 5);
    end

    settle();
    if (failures == 0 && outstanding == 0) begin
      $display("visibility_pattern_checker_unit: match");
    end else begin
      $display("visibility_pattern_checker_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/vpc_pkg.sv
sv/vpc_if.sv
sv/vpc_front.sv
sv/vpc_queue.sv
sv/vpc_back.sv
sv/visibility_pattern_checker_unit.sv
sv/vpc_checker.sv
verif/vpc_summary_checker.sv
verif/tb_visibility_pattern_checker_unit.sv
